// File: rtl/core/blz_pkg.sv
// Shared constants, codes and controller/datapath types of the block LZ decompressor.
package blz_pkg;

  localparam int unsigned BLOCK_BYTES = 65536;
  localparam int unsigned AW = $clog2(BLOCK_BYTES);
  localparam int unsigned FW = AW + 1;
  localparam int unsigned RW = 17;
  localparam int unsigned SW = 30;
  localparam int unsigned LW = 6;

  localparam logic REG_EXPECTED_SIZE = 1'b0;

  localparam logic [SW-1:0] SIZE_LIMIT = 30'd536870912;
  localparam logic [7:0] CTRL_END = 8'hE0;
  localparam logic [7:0] MATCH_BASE = 8'h20;
  localparam int unsigned MATCH_LEN_ADD = 2;
  localparam int unsigned COPY_LEN_ADD = 4;
  localparam int unsigned MIN_BYTES = 4;

  typedef enum logic [1:0] {
    KIND_DATA = 2'd0,
    KIND_OK   = 2'd1,
    KIND_BAD  = 2'd2
  } kind_e;

  typedef struct packed {
    logic cap;
    logic set_err;
    logic fill_clr;
    logic hold_ctrl;
    logic hold_low;
    logic tok_lit;
    logic tok_match;
    logic tok_copy;
    logic lit_load;
    logic put_lit;
    logic cpy_load;
    logic rd;
    logic put_cpy;
    logic emit_status;
    logic stream_clr;
    logic tok_open;
  } dp_cmd_t;

  typedef struct packed {
    logic err;
    logic cfg_bad;
    logic b_ge_e0;
    logic cnt_zero;
    logic b_ge_20;
    logic lit_one;
    logic cpy_one;
    logic ref_bad;
    logic room_ok;
    logic slot_free;
    logic last;
  } dp_sts_t;

endpackage

// File: rtl/core/blz_if.sv
// Input and output channel interfaces of the block LZ decompressor.
interface blz_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface blz_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] out_kind;
  logic       out_last;

  modport source (output valid, output out_byte, output out_kind, output out_last, input ready);
  modport sink (input valid, input out_byte, input out_kind, input out_last, output ready);
endinterface

// File: rtl/core/blz_dp.sv
// Datapath of the block LZ decompressor: history memory, counters, token checks and output register.
module blz_dp (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  blz_pkg::dp_cmd_t  cmd_i,
  output blz_pkg::dp_sts_t  sts_o,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  input  logic [29:0]       exp_size_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [7:0]        out_byte_o,
  output logic [1:0]        out_kind_o,
  output logic              out_last_o
);

  localparam int unsigned AW = blz_pkg::AW;
  localparam int unsigned FW = blz_pkg::FW;
  localparam int unsigned RW = blz_pkg::RW;
  localparam int unsigned SW = blz_pkg::SW;
  localparam int unsigned LW = blz_pkg::LW;

  logic [7:0]    mem [blz_pkg::BLOCK_BYTES];
  logic [7:0]    rdata_q;

  logic [7:0]    byte_q;
  logic          last_q;
  logic [7:0]    held_q;
  logic [7:0]    low_q;
  logic [4:0]    lit_left_q;
  logic [2:0]    seen_q;
  logic          err_q;
  logic [SW-1:0] total_q;
  logic [FW-1:0] fill_q;
  logic [LW-1:0] tok_len_q;
  logic [AW-1:0] tok_src_q;
  logic          ref_bad_q;
  logic [LW-1:0] cpy_left_q;

  logic          out_valid_q;
  logic [7:0]    out_byte_q;
  blz_pkg::kind_e out_kind_q;
  logic          out_last_q;

  logic [RW-1:0] fill_ext;
  logic [RW-1:0] back_dist;
  logic [LW-1:0] match_len;
  logic          match_bad;
  logic [AW-1:0] match_src;
  logic [LW-1:0] copy_len;
  logic [15:0]   copy_off;
  logic          copy_bad;
  logic [SW:0]   total_sum;
  logic [FW:0]   fill_sum;
  logic          stream_ok;
  logic          mem_we;
  logic [7:0]    mem_wdata;
  logic          put;

  assign fill_ext  = RW'(fill_q);
  assign back_dist = RW'({held_q[4:0], byte_q}) + RW'(1);
  assign match_len = LW'(held_q[7:5]) + LW'(blz_pkg::MATCH_LEN_ADD);
  assign match_bad = back_dist > fill_ext;
  assign match_src = AW'(fill_ext - back_dist);
  assign copy_len  = LW'(held_q[4:0]) + LW'(blz_pkg::COPY_LEN_ADD);
  assign copy_off  = {byte_q, low_q};
  assign copy_bad  = RW'(copy_off) >= fill_ext;

  assign total_sum = (SW+1)'(total_q) + (SW+1)'(tok_len_q);
  assign fill_sum  = (FW+1)'(fill_q) + (FW+1)'(tok_len_q);

  assign stream_ok = !err_q && !cmd_i.tok_open && (seen_q >= 3'(blz_pkg::MIN_BYTES)) &&
                     (total_q == exp_size_i) && (fill_q == '0);

  assign put       = cmd_i.put_lit || cmd_i.put_cpy;
  assign mem_we    = put;
  assign mem_wdata = cmd_i.put_lit ? byte_q : rdata_q;

  always_comb begin
    sts_o.err       = err_q;
    sts_o.cfg_bad   = (exp_size_i == '0) || (exp_size_i > blz_pkg::SIZE_LIMIT);
    sts_o.b_ge_e0   = byte_q >= blz_pkg::CTRL_END;
    sts_o.cnt_zero  = byte_q == blz_pkg::CTRL_END;
    sts_o.b_ge_20   = byte_q >= blz_pkg::MATCH_BASE;
    sts_o.lit_one   = lit_left_q == 5'd1;
    sts_o.cpy_one   = cpy_left_q == LW'(1);
    sts_o.ref_bad   = ref_bad_q;
    sts_o.room_ok   = !(total_sum > (SW+1)'(exp_size_i)) &&
                      !(fill_sum > (FW+1)'(blz_pkg::BLOCK_BYTES));
    sts_o.slot_free = !out_valid_q || out_ready_i;
    sts_o.last      = last_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[fill_q[AW-1:0]] <= mem_wdata;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[tok_src_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      byte_q <= in_byte_i;
      last_q <= in_last_i;
    end
    if (cmd_i.tok_lit) begin
      tok_len_q <= LW'(byte_q[4:0]);
      ref_bad_q <= 1'b0;
    end else if (cmd_i.tok_match) begin
      tok_len_q <= match_len;
      tok_src_q <= match_src;
      ref_bad_q <= match_bad;
    end else if (cmd_i.tok_copy) begin
      tok_len_q <= copy_len;
      tok_src_q <= AW'(copy_off);
      ref_bad_q <= copy_bad;
    end else if (cmd_i.put_cpy) begin
      tok_src_q <= tok_src_q + AW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q     <= '0;
      low_q      <= '0;
      lit_left_q <= '0;
      seen_q     <= '0;
      err_q      <= 1'b0;
      total_q    <= '0;
      fill_q     <= '0;
      cpy_left_q <= '0;
    end else if (cmd_i.stream_clr) begin
      held_q     <= '0;
      low_q      <= '0;
      lit_left_q <= '0;
      seen_q     <= '0;
      err_q      <= 1'b0;
      total_q    <= '0;
      fill_q     <= '0;
      cpy_left_q <= '0;
    end else begin
      if (cmd_i.cap && (seen_q != 3'(blz_pkg::MIN_BYTES))) begin
        seen_q <= seen_q + 3'd1;
      end
      if (cmd_i.set_err) begin
        err_q <= 1'b1;
      end
      if (cmd_i.hold_ctrl) begin
        held_q <= byte_q;
      end
      if (cmd_i.hold_low) begin
        low_q <= byte_q;
      end
      if (cmd_i.lit_load) begin
        lit_left_q <= tok_len_q[4:0];
      end else if (cmd_i.put_lit) begin
        lit_left_q <= lit_left_q - 5'd1;
      end
      if (cmd_i.cpy_load) begin
        cpy_left_q <= tok_len_q;
      end else if (cmd_i.put_cpy) begin
        cpy_left_q <= cpy_left_q - LW'(1);
      end
      if (cmd_i.fill_clr) begin
        fill_q <= '0;
      end else if (put) begin
        fill_q <= fill_q + FW'(1);
      end
      if (put) begin
        total_q <= total_q + SW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (put || cmd_i.emit_status) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (put) begin
      out_byte_q <= mem_wdata;
      out_kind_q <= blz_pkg::KIND_DATA;
      out_last_q <= 1'b0;
    end else if (cmd_i.emit_status) begin
      out_byte_q <= '0;
      out_kind_q <= stream_ok ? blz_pkg::KIND_OK : blz_pkg::KIND_BAD;
      out_last_q <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_byte_q;
  assign out_kind_o  = out_kind_q;
  assign out_last_o  = out_last_q;

  a_fill_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FW'(blz_pkg::BLOCK_BYTES))
    else $error("block fill exceeds the block size");

  a_status_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && (out_kind_q != blz_pkg::KIND_DATA)) |-> (out_last_q && (out_byte_q == '0)))
    else $error("status beat without last flag or with nonzero byte");

  a_copy_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.put_cpy |-> (cpy_left_q != '0))
    else $error("copy byte emitted with no bytes left");

endmodule

// File: rtl/core/blz_ctrl.sv
// Controller of the block LZ decompressor: token parse phase and per-beat sequencing.
module blz_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  blz_pkg::dp_sts_t  sts_i,
  output blz_pkg::dp_cmd_t  cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DEC  = 3'd1;
  localparam logic [2:0] ST_ROOM = 3'd2;
  localparam logic [2:0] ST_RD   = 3'd3;
  localparam logic [2:0] ST_WR   = 3'd4;
  localparam logic [2:0] ST_FIN  = 3'd5;

  localparam logic [2:0] PH_CTRL  = 3'd0;
  localparam logic [2:0] PH_LIT   = 3'd1;
  localparam logic [2:0] PH_MLOW  = 3'd2;
  localparam logic [2:0] PH_CLOW  = 3'd3;
  localparam logic [2:0] PH_CHIGH = 3'd4;

  logic [2:0] state_q, state_d;
  logic [2:0] phase_q, phase_d;
  logic       tok_lit_q, tok_lit_d;
  logic [2:0] done_state;

  assign done_state = sts_i.last ? ST_FIN : ST_IDLE;

  always_comb begin
    cmd_o          = '0;
    cmd_o.tok_open = phase_q != PH_CTRL;
    state_d        = state_q;
    phase_d        = phase_q;
    tok_lit_d      = tok_lit_q;
    in_ready_o     = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cap = 1'b1;
          state_d   = ST_DEC;
        end
      end
      ST_DEC: begin
        if (sts_i.err) begin
          state_d = done_state;
        end else if (sts_i.cfg_bad) begin
          cmd_o.set_err = 1'b1;
          state_d       = done_state;
        end else begin
          case (phase_q)
            PH_CTRL: begin
              if (sts_i.b_ge_e0) begin
                if (sts_i.cnt_zero) begin
                  cmd_o.fill_clr = 1'b1;
                  state_d        = done_state;
                end else begin
                  cmd_o.tok_lit = 1'b1;
                  tok_lit_d     = 1'b1;
                  state_d       = ST_ROOM;
                end
              end else begin
                cmd_o.hold_ctrl = 1'b1;
                phase_d         = sts_i.b_ge_20 ? PH_MLOW : PH_CLOW;
                state_d         = done_state;
              end
            end
            PH_LIT: begin
              if (sts_i.slot_free) begin
                cmd_o.put_lit = 1'b1;
                if (sts_i.lit_one) begin
                  phase_d = PH_CTRL;
                end
                state_d = done_state;
              end
            end
            PH_MLOW: begin
              cmd_o.tok_match = 1'b1;
              tok_lit_d       = 1'b0;
              phase_d         = PH_CTRL;
              state_d         = ST_ROOM;
            end
            PH_CLOW: begin
              cmd_o.hold_low = 1'b1;
              phase_d        = PH_CHIGH;
              state_d        = done_state;
            end
            PH_CHIGH: begin
              cmd_o.tok_copy = 1'b1;
              tok_lit_d      = 1'b0;
              phase_d        = PH_CTRL;
              state_d        = ST_ROOM;
            end
            default: begin
              phase_d = PH_CTRL;
              state_d = done_state;
            end
          endcase
        end
      end
      ST_ROOM: begin
        if (sts_i.ref_bad || !sts_i.room_ok) begin
          cmd_o.set_err = 1'b1;
          state_d       = done_state;
        end else if (tok_lit_q) begin
          cmd_o.lit_load = 1'b1;
          phase_d        = PH_LIT;
          state_d        = done_state;
        end else begin
          cmd_o.cpy_load = 1'b1;
          state_d        = ST_RD;
        end
      end
      ST_RD: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_WR;
      end
      ST_WR: begin
        if (sts_i.slot_free) begin
          cmd_o.put_cpy = 1'b1;
          state_d       = sts_i.cpy_one ? done_state : ST_RD;
        end
      end
      ST_FIN: begin
        if (sts_i.slot_free) begin
          cmd_o.emit_status = 1'b1;
          cmd_o.stream_clr  = 1'b1;
          phase_d           = PH_CTRL;
          state_d           = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      phase_q   <= PH_CTRL;
      tok_lit_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      phase_q   <= phase_d;
      tok_lit_q <= tok_lit_d;
    end
  end

  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.put_lit, cmd_o.put_cpy, cmd_o.emit_status}))
    else $error("more than one beat loaded into the output register");

  a_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.put_lit || cmd_o.put_cpy || cmd_o.emit_status) |-> sts_i.slot_free)
    else $error("output register overwritten while occupied");

  a_stream_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.stream_clr |=> ((phase_q == PH_CTRL) && (state_q == ST_IDLE)))
    else $error("stream end did not return the parser to its start");

endmodule

// File: rtl/core/block_lz_decompressor.sv
// Top level of the block LZ decompressor: channels, configuration register and core modules.
//
//   channel   direction  beat contents                     handshake
//   in_i      sink       in_byte, in_last                  valid/ready
//   out_o     source     out_byte, out_kind, out_last      valid/ready
//   apb       slave      expected_size at byte address 0   psel/penable, pready high
//
// A literal byte or a plain control byte is captured in the idle state and decoded; a byte that starts a literal
// run or completes a match or copy token also passes the room state for the size and reference checks.
// Each match or copy byte takes one history memory read and one write,
// and the last input byte adds a final state that emits the status beat.
// Reset is asynchronous and clears all control state; the history needs no clearing.
// A stalled output holds the sequencer when it has a beat to load, and input is refused while it is held.
module block_lz_decompressor (
  input  logic        clk_i,
  input  logic        rst_ni,
  blz_in_if.sink      in_i,
  blz_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [29:0]      exp_q;
  logic             reg_sel;
  blz_pkg::dp_cmd_t cmd;
  blz_pkg::dp_sts_t sts;

  assign reg_sel = paddr[2] == blz_pkg::REG_EXPECTED_SIZE;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {2'b00, exp_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= '0;
    end else if (psel && penable && pwrite && reg_sel) begin
      exp_q <= pwdata[29:0];
    end
  end

  blz_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  blz_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_byte_i   (in_i.in_byte),
    .in_last_i   (in_i.in_last),
    .exp_size_i  (exp_q),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_byte_o  (out_o.out_byte),
    .out_kind_o  (out_o.out_kind),
    .out_last_o  (out_o.out_last)
  );

endmodule
